FILE: rtl/pce_pkg.sv
`default_nettype none
package pce_pkg;

	// Fraction bits of the angle fields; the angle datapath is sized for this value.
	localparam int ANGLE_FRAC_BITS = 28;

	// One pendulum as it arrives on the input channel.
	typedef struct packed {
		logic signed [31:0] angle_now;
		logic signed [31:0] angle_before;
		logic [31:0]        mass;
		logic [31:0]        gravity_coef;
		logic [31:0]        length;
		logic [31:0]        stiffness;
		logic               last_in_chain;
	} pce_in_t;

	// Energies of a finished chain.
	typedef struct packed {
		logic signed [63:0] kinetic_energy;
		logic signed [63:0] coupling_energy;
		logic signed [63:0] gravity_energy;
		logic signed [63:0] total_energy;
	} pce_out_t;

	// Fixed-point constants in Q2.30.
	localparam logic [34:0] PI_Q30     = 35'd3373259426;
	localparam logic [34:0] TWO_PI_Q30 = 35'd6746518852;
	localparam logic [34:0] HALF_PI_Q30 = 35'd1686629713;
	localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
	localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;

	// Register indexes on the configuration port.
	localparam logic [0:0] REG_INV_DT = 1'b0;
	localparam logic [0:0] REG_PERIODIC = 1'b1;

	// Arctangent table, Q30.
	function automatic logic [29:0] atan_q30(input logic [4:0] i);
		case (i)
			5'd0:  atan_q30 = 30'h3243F6A8;
			5'd1:  atan_q30 = 30'h1DAC6705;
			5'd2:  atan_q30 = 30'h0FADBAFC;
			5'd3:  atan_q30 = 30'h07F56EA6;
			5'd4:  atan_q30 = 30'h03FEAB76;
			5'd5:  atan_q30 = 30'h01FFD55B;
			5'd6:  atan_q30 = 30'h00FFFAAA;
			5'd7:  atan_q30 = 30'h007FFF55;
			5'd8:  atan_q30 = 30'h003FFFEA;
			5'd9:  atan_q30 = 30'h001FFFFD;
			5'd10: atan_q30 = 30'h000FFFFF;
			5'd11: atan_q30 = 30'h0007FFFF;
			5'd12: atan_q30 = 30'h0003FFFF;
			5'd13: atan_q30 = 30'h0001FFFF;
			5'd14: atan_q30 = 30'h0000FFFF;
			5'd15: atan_q30 = 30'h00007FFF;
			5'd16: atan_q30 = 30'h00003FFF;
			5'd17: atan_q30 = 30'h00001FFF;
			5'd18: atan_q30 = 30'h00000FFF;
			5'd19: atan_q30 = 30'h000007FF;
			5'd20: atan_q30 = 30'h000003FF;
			5'd21: atan_q30 = 30'h000001FF;
			5'd22: atan_q30 = 30'h000000FF;
			5'd23: atan_q30 = 30'h0000007F;
			5'd24: atan_q30 = 30'h0000003F;
			5'd25: atan_q30 = 30'h0000001F;
			5'd26: atan_q30 = 30'h0000000F;
			5'd27: atan_q30 = 30'h00000008;
			5'd28: atan_q30 = 30'h00000004;
			5'd29: atan_q30 = 30'h00000002;
			default: atan_q30 = 30'h0;
		endcase
	endfunction

	// Saturating signed 64-bit addition.
	function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63])
			sat_add = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		else
			sat_add = s[63:0];
	endfunction

endpackage
`default_nettype wire

FILE: rtl/pce_mul.sv
`default_nettype none
// Shared multiplier: one 64x32 product done as two 32x32 halves in sequence,
// then shifted right and saturated to 2^64-1.
module pce_mul
	import pce_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] a,
	input  wire logic [31:0] b,
	input  wire logic [4:0]  sh,
	output logic             done,
	output logic [63:0]      result
);
	logic [1:0]  phase_q;
	logic [63:0] a_q;
	logic [31:0] b_q;
	logic [4:0]  sh_q;
	logic [63:0] p0_q;
	logic [31:0] mul_a;
	logic [63:0] prod;
	logic [95:0] full;
	logic [95:0] shifted;

	// Sequence the two partial products.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 2'd0;
		end else begin
			if (start)
				phase_q <= 2'd1;
			else if (phase_q == 2'd1)
				phase_q <= 2'd2;
			else
				phase_q <= 2'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			sh_q <= sh;
		end
		if (phase_q == 2'd1)
			p0_q <= prod;
	end

	// One 32x32 multiplier: low half first, high half next, then combine.
	always_comb begin
		mul_a = (phase_q == 2'd1) ? a_q[31:0] : a_q[63:32];
		prod = {32'd0, mul_a} * {32'd0, b_q};
		full = {prod, 32'd0} + {32'd0, p0_q};
		shifted = full >> sh_q;
		done = (phase_q == 2'd2);
		result = (shifted[95:64] != 32'd0) ? {64{1'b1}} : shifted[63:0];
	end
endmodule
`default_nettype wire

FILE: rtl/pce_cordic.sv
`default_nettype none
// Cosine by CORDIC rotation, one iteration per cycle; gives 1-cos a in Q30.
module pce_cordic
	import pce_pkg::*;
#(
	parameter int CORDIC_STEPS = 24
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [31:0] angle,
	output logic                    done,
	output logic [33:0]             one_minus_cos
);
	localparam int NSTEP = (CORDIC_STEPS < 30) ? CORDIC_STEPS : 30;

	typedef enum logic [3:0] {
		C_IDLE = 4'b0001,
		C_MOD  = 4'b0010,
		C_ROT  = 4'b0100,
		C_DONE = 4'b1000
	} cstate_t;

	cstate_t            state_q;
	logic [34:0]        x_q;
	logic               neg_q;
	logic signed [35:0] cx_q;
	logic signed [35:0] cy_q;
	logic signed [35:0] z_q;
	logic [4:0]         i_q;
	logic [33:0]        w_abs;
	logic [34:0]        red;
	logic [34:0]        fold;
	logic               fneg;
	logic signed [35:0] cxn;
	logic signed [35:0] atn;
	logic signed [36:0] om;

	// Angle in Q2.30 as magnitude.
	always_comb begin
		logic signed [33:0] w;
		w = 34'(angle) <<< (30 - ANGLE_FRAC_BITS);
		w_abs = w[33] ? 34'(-w) : w;
	end

	// Fold the reduced angle into the first quadrant.
	always_comb begin
		red = x_q;
		fneg = 1'b0;
		if (red > PI_Q30)
			red = TWO_PI_Q30 - red;
		fold = red;
		if (red > HALF_PI_Q30) begin
			fold = PI_Q30 - red;
			fneg = 1'b1;
		end
		atn = 36'(atan_q30(i_q));
		cxn = neg_q ? -cx_q : cx_q;
		om = 37'(ONE_Q30) - 37'(cxn);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
		end else begin
			case (state_q)
				C_IDLE: if (start) state_q <= C_MOD;
				C_MOD: if (x_q < TWO_PI_Q30) state_q <= C_ROT;
				C_ROT: if (i_q == 5'(NSTEP - 1)) state_q <= C_DONE;
				C_DONE: state_q <= C_IDLE;
				default: state_q <= C_IDLE;
			endcase
		end
	end

	// Datapath: subtract 2*pi until reduced (at most once), then rotate.
	always_ff @(posedge clk) begin
		case (state_q)
			C_IDLE: begin
				x_q <= {1'b0, w_abs};
				i_q <= 5'd0;
			end
			C_MOD: begin
				if (x_q >= TWO_PI_Q30) begin
					x_q <= x_q - TWO_PI_Q30;
				end else begin
					neg_q <= fneg;
					z_q <= 36'(fold);
					cx_q <= 36'(CORDIC_GAIN_Q30);
					cy_q <= 36'sd0;
				end
			end
			C_ROT: begin
				if (!z_q[35]) begin
					cx_q <= cx_q - (cy_q >>> i_q);
					cy_q <= cy_q + (cx_q >>> i_q);
					z_q <= z_q - atn;
				end else begin
					cx_q <= cx_q + (cy_q >>> i_q);
					cy_q <= cy_q - (cx_q >>> i_q);
					z_q <= z_q + atn;
				end
				i_q <= i_q + 5'd1;
			end
			default: ;
		endcase
	end

	assign done = (state_q == C_DONE);
	assign one_minus_cos = om[36] ? 34'd0 : om[33:0];
endmodule
`default_nettype wire

FILE: rtl/pce_seq.sv
`default_nettype none
// Sequencer: walks the term chains through the shared multiplier and keeps
// the chain state and sums.
module pce_seq
	import pce_pkg::*;
#(
	parameter int CORDIC_STEPS = 24
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire pce_in_t     in_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output pce_out_t         out_data,
	input  wire logic [31:0] inv_dt,
	input  wire logic        periodic
);
	localparam int SQ_SH = 2 * ANGLE_FRAC_BITS - 32;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_COS   = 9'b000000010,
		S_KIN   = 9'b000000100,
		S_GRAV  = 9'b000001000,
		S_CPL   = 9'b000010000,
		S_WRAP  = 9'b000100000,
		S_MUL   = 9'b001000000,
		S_TOTAL = 9'b010000000,
		S_OUT   = 9'b100000000
	} state_t;

	// Which term a multiply chain belongs to.
	typedef enum logic [1:0] {
		T_KIN  = 2'd0,
		T_GRAV = 2'd1,
		T_CPL  = 2'd2,
		T_WRAP = 2'd3
	} term_t;

	state_t      state_q;
	term_t       term_q;
	logic [2:0]  step_q;
	pce_in_t     item_q;
	logic [63:0] acc_q;
	logic        cos_start;
	logic        cos_done;
	logic [33:0] omc;
	logic        mul_start_q;
	logic [31:0] mul_b;
	logic [4:0]  mul_sh;
	logic        mul_done;
	logic [63:0] mul_res;
	logic [31:0] prior_angle_q, prior_mass_q, prior_stiff_q, first_angle_q;
	logic        awaiting_first_q;
	logic signed [63:0] kin_q, cpl_q, grav_q;
	logic [2:0]  nsteps;
	logic [63:0] mag;
	logic signed [63:0] pterm, nterm;
	logic [63:0] dsq_now, dsq_prior, dsq_wrap;

	// Squared angle difference in Q32.32.
	function automatic logic [63:0] diff_sq(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [32:0] d;
		logic [32:0] m;
		logic [65:0] p;
		d = 33'(a) - 33'(b);
		m = d[32] ? 33'(-d) : 33'(d);
		p = {33'd0, m} * {33'd0, m};
		diff_sq = 64'(p >> SQ_SH);
	endfunction

	assign dsq_now   = diff_sq(item_q.angle_now, item_q.angle_before);
	assign dsq_prior = diff_sq(prior_angle_q, item_q.angle_now);
	assign dsq_wrap  = diff_sq(item_q.angle_now, first_angle_q);

	// Factor and shift for each step of the active chain.
	always_comb begin
		mul_b = inv_dt;
		mul_sh = 5'd8;
		nsteps = 3'd2;
		case (term_q)
			T_KIN: begin
				if (step_q == 3'd0) begin mul_b = item_q.mass; mul_sh = 5'd16; end
			end
			T_GRAV: begin
				nsteps = 3'd4;
				mul_sh = 5'd16;
				case (step_q)
					3'd0: mul_b = item_q.length;
					3'd1: mul_b = item_q.mass;
					3'd2: mul_b = item_q.gravity_coef;
					default: begin mul_b = inv_dt; mul_sh = 5'd8; end
				endcase
			end
			default: begin
				nsteps = 3'd3;
				mul_sh = 5'd16;
				case (step_q)
					3'd0: mul_b = (term_q == T_CPL) ? prior_mass_q : item_q.mass;
					3'd1: mul_b = (term_q == T_CPL) ? prior_stiff_q : item_q.stiffness;
					default: begin mul_b = inv_dt; mul_sh = 5'd8; end
				endcase
			end
		endcase
		mag = (term_q == T_GRAV) ? mul_res : {1'b0, mul_res[63:1]};
		pterm = mag[63] ? {1'b0, {63{1'b1}}} : mag;
		nterm = mag[63] ? {1'b1, 63'd0} : -$signed(mag);
	end

	// The cosine unit samples the angle straight off the input at the accepting edge.
	pce_cordic #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cos_start), .angle(in_data.angle_now),
		.done(cos_done), .one_minus_cos(omc)
	);

	pce_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start_q), .a(acc_q), .b(mul_b),
		.sh(mul_sh), .done(mul_done), .result(mul_res)
	);

	assign cos_start = (state_q == S_IDLE) && in_valid;
	assign in_stall = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);

	// Control and chain state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			term_q <= T_KIN;
			step_q <= 3'd0;
			mul_start_q <= 1'b0;
			prior_angle_q <= '0;
			prior_mass_q <= '0;
			prior_stiff_q <= '0;
			first_angle_q <= '0;
			awaiting_first_q <= 1'b1;
			kin_q <= '0;
			cpl_q <= '0;
			grav_q <= '0;
		end else begin
			mul_start_q <= 1'b0;
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_COS;
				S_COS: if (cos_done) state_q <= S_KIN;
				S_KIN: begin
					term_q <= T_KIN; step_q <= 3'd0; mul_start_q <= 1'b1;
					state_q <= S_MUL;
				end
				S_GRAV: begin
					term_q <= T_GRAV; step_q <= 3'd0; mul_start_q <= 1'b1;
					state_q <= S_MUL;
				end
				S_CPL: begin
					if (awaiting_first_q) begin
						first_angle_q <= item_q.angle_now;
						awaiting_first_q <= 1'b0;
						state_q <= S_WRAP;
					end else begin
						term_q <= T_CPL; step_q <= 3'd0; mul_start_q <= 1'b1;
						state_q <= S_MUL;
					end
				end
				S_WRAP: begin
					prior_angle_q <= item_q.angle_now;
					prior_mass_q <= item_q.mass;
					prior_stiff_q <= item_q.stiffness;
					if (!item_q.last_in_chain) begin
						state_q <= S_IDLE;
					end else if (periodic) begin
						term_q <= T_WRAP; step_q <= 3'd0; mul_start_q <= 1'b1;
						state_q <= S_MUL;
					end else begin
						state_q <= S_TOTAL;
					end
				end
				S_MUL: begin
					if (mul_done) begin
						if (step_q != nsteps - 3'd1) begin
							step_q <= step_q + 3'd1;
							mul_start_q <= 1'b1;
						end else begin
							case (term_q)
								T_KIN: begin
									kin_q <= sat_add(kin_q, pterm); state_q <= S_GRAV;
								end
								T_GRAV: begin
									grav_q <= sat_add(grav_q, nterm); state_q <= S_CPL;
								end
								T_CPL: begin
									cpl_q <= sat_add(cpl_q, nterm); state_q <= S_WRAP;
								end
								default: begin
									cpl_q <= sat_add(cpl_q, nterm); state_q <= S_TOTAL;
								end
							endcase
						end
					end
				end
				S_TOTAL: state_q <= S_OUT;
				S_OUT: begin
					if (!out_stall) begin
						prior_angle_q <= '0;
						prior_mass_q <= '0;
						prior_stiff_q <= '0;
						first_angle_q <= '0;
						awaiting_first_q <= 1'b1;
						kin_q <= '0;
						cpl_q <= '0;
						grav_q <= '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Payload registers: item, multiply operand and result.
	always_ff @(posedge clk) begin
		if (cos_start)
			item_q <= in_data;
		if (mul_done)
			acc_q <= mul_res;
		case (state_q)
			S_KIN: acc_q <= dsq_now;
			S_GRAV: acc_q <= {28'd0, omc, 2'b00};
			S_CPL: acc_q <= dsq_prior;
			S_WRAP: acc_q <= dsq_wrap;
			S_TOTAL: begin
				out_data.kinetic_energy <= kin_q;
				out_data.coupling_energy <= cpl_q;
				out_data.gravity_energy <= grav_q;
				out_data.total_energy <= sat_add(sat_add(cpl_q, grav_q), kin_q);
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

FILE: rtl/pendulum_chain_energy_top.sv
`default_nettype none
// Pendulum chain energy accumulator. Pendulums enter one per transfer in
// chain order; the transfer flagged last_in_chain yields one result transfer
// with kinetic, coupling, gravity and total energy (signed Q32.32, saturated),
// after which the chain state clears. The cosine runs CORDIC_STEPS rotation
// steps after angle reduction and handoff; up to twelve multiplications then
// follow through one shared 64x32 multiplier. The input is stalled throughout,
// also while the result transfer of the last item is stalled.
// inv_dt_squared (address 0) and periodic_ends (address 4) are to be written
// over the APB port by the user only while the block is idle; the block
// itself does not enforce this.
module pendulum_chain_energy_top
	import pce_pkg::*;
#(
	parameter int CORDIC_STEPS = 24
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire pce_in_t     in_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output pce_out_t         out_data,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	logic [31:0] inv_dt_q;
	logic        periodic_q;
	logic        wr;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_dt_q <= 32'd256;
			periodic_q <= 1'b1;
		end else if (wr && paddr[1:0] == 2'b00) begin
			if (paddr[2] == REG_INV_DT)
				inv_dt_q <= pwdata;
			else
				periodic_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = 32'd0;
		if (paddr[1:0] == 2'b00) begin
			if (paddr[2] == REG_PERIODIC)
				prdata = {31'd0, periodic_q};
			else
				prdata = inv_dt_q;
		end
	end

	pce_seq #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_seq (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.inv_dt(inv_dt_q), .periodic(periodic_q)
	);

`ifndef ASSERT_OFF
	// No item is taken while a result waits.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input taken during output");
	// A taken item stalls the input on the next cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall) else $error("input not stalled");
	// A result appears only after a stall period.
	a_out_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall)) else $error("spurious result");
`endif
endmodule
`default_nettype wire

FILE: sim/pendulum_chain_energy_checker.sv
`timescale 1ns / 1ps
module pendulum_chain_energy_checker
	import pce_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire pce_in_t     in_data,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire pce_out_t    out_data,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	input  wire logic        pready,
	output int               error_count,
	output int               pending_count
);

	localparam int FRAC = 28;
	localparam int STEPS = 24;
	localparam logic signed [63:0] MAX64 = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] MIN64 = 64'sh8000_0000_0000_0000;

	// Predictor state mirrors the chain registers of the block.
	logic [31:0] step_scale;
	logic        wrap_on;
	logic [31:0] last_angle, last_mass, last_stiff, head_angle;
	logic        new_chain;
	logic signed [63:0] kin_acc, cpl_acc, grav_acc;
	pce_out_t    energy_queue[$];

	function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63])
			return s[64] ? MIN64 : MAX64;
		return s[63:0];
	endfunction

	// Truncating product with shift, saturated to all ones.
	function automatic logic [63:0] scale_mul(input logic [63:0] a,
			input logic [31:0] b, input int sh);
		logic [95:0] p;
		p = {32'd0, a} * {64'd0, b};
		p = p >> sh;
		if (p[95:64] != 0)
			return '1;
		return p[63:0];
	endfunction

	function automatic logic [63:0] sq_diff(input logic [31:0] a, input logic [31:0] b);
		logic signed [32:0] d;
		logic [32:0] m;
		logic [65:0] sq;
		d = $signed({a[31], a}) - $signed({b[31], b});
		m = d[32] ? -d : d;
		sq = {33'd0, m} * {33'd0, m};
		return 64'(sq >> (2 * FRAC - 32));
	endfunction

	function automatic logic signed [63:0] pos_clip(input logic [63:0] m);
		return m[63] ? MAX64 : $signed(m);
	endfunction

	function automatic logic signed [63:0] neg_clip(input logic [63:0] m);
		return m[63] ? MIN64 : -$signed(m);
	endfunction

	function automatic logic [63:0] one_minus_cosine(input logic [31:0] a);
		longint w, x, cx, cy, z, nx, ny;
		logic [63:0] atan_v;
		bit flip;
		w = longint'($signed(a)) * (longint'(1) << (30 - FRAC));
		x = w < 0 ? -w : w;
		flip = 0;
		x = x % longint'(TWO_PI_Q30);
		if (x > longint'(PI_Q30)) x = longint'(TWO_PI_Q30) - x;
		if (x > longint'(HALF_PI_Q30)) begin
			x = longint'(PI_Q30) - x;
			flip = 1;
		end
		cx = 652032874;
		cy = 0;
		z = x;
		for (int i = 0; i < STEPS && i < 30; i++) begin
			atan_v = {34'd0, atan_q30(i[4:0])};
			if (z >= 0) begin
				nx = cx - (cy >>> i);
				ny = cy + (cx >>> i);
				z -= longint'(atan_v);
			end else begin
				nx = cx + (cy >>> i);
				ny = cy - (cx >>> i);
				z += longint'(atan_v);
			end
			cx = nx;
			cy = ny;
		end
		if (flip) cx = -cx;
		w = 1073741824 - cx;
		return w < 0 ? 64'd0 : w;
	endfunction

	function automatic logic [63:0] coupling_size(input logic [63:0] d2,
			input logic [31:0] m, input logic [31:0] k);
		return scale_mul(scale_mul(scale_mul(d2, m, 16), k, 16), step_scale, 8) >> 1;
	endfunction

	// Advance the chain by one pendulum; queue the energies on the last one.
	task automatic absorb_pendulum(input pce_in_t p);
		logic [63:0] mag;
		pce_out_t e;
		mag = scale_mul(scale_mul(sq_diff(p.angle_now, p.angle_before), p.mass, 16),
			step_scale, 8) >> 1;
		kin_acc = add_sat(kin_acc, pos_clip(mag));
		mag = one_minus_cosine(p.angle_now) << 2;
		mag = scale_mul(mag, p.length, 16);
		mag = scale_mul(mag, p.mass, 16);
		mag = scale_mul(mag, p.gravity_coef, 16);
		mag = scale_mul(mag, step_scale, 8);
		grav_acc = add_sat(grav_acc, neg_clip(mag));
		if (new_chain) begin
			head_angle = p.angle_now;
			new_chain = 0;
		end else begin
			mag = coupling_size(sq_diff(last_angle, p.angle_now), last_mass, last_stiff);
			cpl_acc = add_sat(cpl_acc, neg_clip(mag));
		end
		last_angle = p.angle_now;
		last_mass = p.mass;
		last_stiff = p.stiffness;
		if (p.last_in_chain) begin
			if (wrap_on) begin
				mag = coupling_size(sq_diff(p.angle_now, head_angle), p.mass, p.stiffness);
				cpl_acc = add_sat(cpl_acc, neg_clip(mag));
			end
			e.kinetic_energy = kin_acc;
			e.coupling_energy = cpl_acc;
			e.gravity_energy = grav_acc;
			e.total_energy = add_sat(add_sat(cpl_acc, grav_acc), kin_acc);
			energy_queue.push_back(e);
			{last_angle, last_mass, last_stiff, head_angle} = '0;
			new_chain = 1;
			kin_acc = 0;
			cpl_acc = 0;
			grav_acc = 0;
		end
	endtask

	task automatic compare_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			error_count++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
		end
	endtask

	// Watch the register port and both channels.
	always @(posedge clk or negedge arst_n) begin
		pce_out_t want;
		if (!arst_n) begin
			step_scale = 32'd256;
			wrap_on = 1;
			{last_angle, last_mass, last_stiff, head_angle} = '0;
			new_chain = 1;
			kin_acc = 0;
			cpl_acc = 0;
			grav_acc = 0;
			energy_queue.delete();
			error_count = 0;
			pending_count = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_INV_DT)
					step_scale = pwdata;
				else
					wrap_on = pwdata[0];
			end
			if (in_valid && !in_stall)
				absorb_pendulum(in_data);
			if (out_valid && !out_stall) begin
				if (energy_queue.size() == 0) begin
					error_count++;
					$display("%0t: unexpected result transfer, expected none, actual %h",
						$time, out_data);
				end else begin
					want = energy_queue.pop_front();
					compare_field("kinetic", want.kinetic_energy, out_data.kinetic_energy);
					compare_field("coupling", want.coupling_energy, out_data.coupling_energy);
					compare_field("gravity", want.gravity_energy, out_data.gravity_energy);
					compare_field("total", want.total_energy, out_data.total_energy);
				end
			end
			pending_count = energy_queue.size();
		end
	end

endmodule

FILE: sim/pendulum_chain_energy_top_test.sv
`timescale 1ns / 1ps
module pendulum_chain_energy_top_test;
	import pce_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;

	logic        clk, arst_n;
	logic        in_valid, in_stall, out_valid, out_stall;
	pce_in_t     in_data;
	pce_out_t    out_data;
	logic        psel, penable, pwrite, pready;
	logic [2:0]  paddr;
	logic [31:0] pwdata, prdata;
	int          error_count, pending_count;
	int          send_idle_pct, recv_idle_pct;
	longint      cycle_count;

	pendulum_chain_energy_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	pendulum_chain_energy_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.error_count(error_count), .pending_count(pending_count)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// Watchdog on total run length.
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// Receiver stalls at random.
	always @(posedge clk)
		out_stall <= ($urandom_range(99) < recv_idle_pct);

	task automatic write_reg(input logic [0:0] idx, input logic [31:0] value);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
	endtask

	// One pendulum transfer, with an optional idle gap before it.
	task automatic send_pendulum(input pce_in_t p);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		in_data <= p;
		do @(posedge clk); while (in_stall);
	endtask

	// Wait for an edge first so the checker has counted the last transfer.
	task automatic drain_block();
		in_valid <= 0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_angle();
		case ($urandom_range(5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return $urandom_range(32'h3000_0000) - 32'h1800_0000;
			default: return $urandom_range(32'h0080_0000) - 32'h0040_0000;
		endcase
	endfunction

	function automatic logic [31:0] pick_coef();
		case ($urandom_range(7))
			0: return 32'hFFFF_FFFF;
			1: return 32'd0;
			2: return $urandom;
			default: return $urandom_range(32'h0004_0000);
		endcase
	endfunction

	function automatic pce_in_t random_pendulum(input bit tail);
		pce_in_t p;
		p.angle_now = pick_angle();
		p.angle_before = ($urandom_range(3) == 0) ? pick_angle() :
			p.angle_now + $urandom_range(32'h0010_0000) - 32'h0008_0000;
		p.mass = pick_coef();
		p.gravity_coef = pick_coef();
		p.length = pick_coef();
		p.stiffness = pick_coef();
		p.last_in_chain = tail;
		return p;
	endfunction

	task automatic send_chain(input int count);
		for (int i = 0; i < count; i++)
			send_pendulum(random_pendulum(i == count - 1));
	endtask

	initial begin
		pce_in_t p;
		int sent;
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		out_stall = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = '0;
		pwdata = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: extremes of every field, then a chain at angles of pi, -pi and pi/2, under the reset settings.
		p = '0;
		p.last_in_chain = 1;
		send_pendulum(p);
		p = '1;
		send_pendulum(p);
		p.angle_now = 32'h7FFF_FFFF;
		p.angle_before = 32'h8000_0000;
		p.last_in_chain = 0;
		send_pendulum(p);
		p.angle_now = 32'h8000_0000;
		p.angle_before = 32'h7FFF_FFFF;
		p.last_in_chain = 1;
		send_pendulum(p);
		p = '0;
		p.angle_now = 32'h3243_F6A9;
		p.mass = 32'h0001_0000;
		p.gravity_coef = 32'h0009_CE00;
		p.length = 32'h0001_0000;
		p.stiffness = 32'h0002_0000;
		send_pendulum(p);
		p.angle_now = 32'hCDBC_0957;
		send_pendulum(p);
		p.angle_now = 32'h1921_FB54;
		p.last_in_chain = 1;
		send_pendulum(p);
		drain_block();

		// Free ends, then extreme time scales.
		write_reg(REG_PERIODIC, 32'd0);
		write_reg(REG_INV_DT, 32'hFFFF_FFFF);
		send_chain(3);
		p = '1;
		p.angle_now = 32'h4000_0000;
		send_pendulum(p);
		drain_block();
		write_reg(REG_INV_DT, 32'd0);
		write_reg(REG_PERIODIC, 32'd1);
		send_chain(4);
		drain_block();

		// Random chains across settings and idling phases.
		sent = 0;
		for (int phase = 0; phase < 6; phase++) begin
			case (phase / 2)
				0: begin send_idle_pct = 21; recv_idle_pct = 77; end
				1: begin send_idle_pct = 77; recv_idle_pct = 21; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			case (phase)
				0: write_reg(REG_INV_DT, 32'd256);
				1: write_reg(REG_INV_DT, $urandom);
				2: write_reg(REG_INV_DT, 32'hFFFF_FFFF);
				3: write_reg(REG_INV_DT, $urandom_range(4096));
				4: write_reg(REG_INV_DT, 32'd0);
				default: write_reg(REG_INV_DT, 32'd256);
			endcase
			write_reg(REG_PERIODIC, {31'd0, phase[0]});
			while (sent < (phase + 1) * 250) begin
				int n;
				n = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 8);
				send_chain(n);
				sent += n;
			end
			drain_block();
		end

		recv_idle_pct = 0;
		if (error_count == 0 && pending_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
